[hw/rtl/htfd_pkg.sv]
// Shared types, constants and helper functions for the humidity and temperature
// frame decoder. Has no dependencies; every other file of the block imports it.
package htfd_pkg;

  // Result status codes, in priority order.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUS_ERR  = 2'd1;
  localparam logic [1:0] ST_TEMP_CRC = 2'd2;
  localparam logic [1:0] ST_HUM_CRC  = 2'd3;

  // Byte positions within the six-byte frame.
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // CRC-8 settings: polynomial x^8+x^5+x^4+1, preset to all ones.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scale factors and offsets of the conversions.
  localparam logic [14:0] TEMP_C_SCALE = 15'd17500;
  localparam logic [14:0] TEMP_F_SCALE = 15'd31500;
  localparam logic [14:0] HUM_SCALE    = 15'd10000;
  localparam logic [15:0] TEMP_C_OFS   = 16'd4500;
  localparam logic [15:0] TEMP_F_OFS   = 16'd4900;
  localparam logic [16:0] FULL_SCALE   = 17'd65535;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;

  // One decoded frame waiting for conversion.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
  } job_t;

  // Push request from the front part into the queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One byte of CRC-8, MSB first, eight shift steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Floor of n / 65535 for n below 2^31. With q = n >> 16 the remainder
  // n - q*65535 equals n[15:0] + q, which stays below twice the divisor,
  // so a single compare fixes the quotient.
  function automatic logic [14:0] div_full_scale(input logic [30:0] n);
    logic [14:0] q;
    logic [16:0] r;
    q = n[30:16];
    r = {1'b0, n[15:0]} + {2'b00, q};
    if (r >= FULL_SCALE) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

endpackage

[hw/rtl/humidity_temp_frame_decoder.sv]
// Top level of the humidity and temperature frame decoder: front part, job
// queue and conversion back end. Depends on htfd_pkg, htfd_front, htfd_queue, htfd_back.

// The decoder takes one frame byte per clock cycle, every cycle, as long as the
// two-entry job queue has room. The front part tracks the byte position and runs
// the CRC-8 on each byte as it is taken, so bytes never wait on each other. After
// a frame's sixth byte is taken, its result passes through the queue and the
// product stage into the output register, where it sits until it is taken. Input
// stall rises only when the queue is full. That happens only after the output
// side has held off long enough for the output register, the product stage and
// both queue entries to fill.
module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               bus_error_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [14:0] temp_centi_c_o,
  output logic signed [15:0] temp_centi_f_o,
  output logic [13:0]        humid_centi_pct_o
);

  logic   in_accept;
  push_t  push;
  job_t   head;
  qstat_t qstat;
  logic   pop;

  // Input request handshake.
  assign in_stall_o = qstat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .bus_error_i   (bus_error_i),
    .push_o        (push)
  );

  htfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  htfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .qstat_i           (qstat),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .temp_centi_c_o    (temp_centi_c_o),
    .temp_centi_f_o    (temp_centi_f_o),
    .humid_centi_pct_o (humid_centi_pct_o)
  );

  // A finished frame is never offered to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push.valid && qstat.full))
    else $error("frame pushed into a full queue");

  // A failed frame carries zero readings.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (temp_centi_c_o == '0 && temp_centi_f_o == '0 && humid_centi_pct_o == '0))
    else $error("nonzero reading with error status");

  // Readings of a good frame stay inside the sensor range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |->
      (humid_centi_pct_o <= 14'd10000 && temp_centi_c_o >= -15'sd4500
       && temp_centi_f_o >= -16'sd4900))
    else $error("reading out of range");

  // The back end only pops when the queue holds an entry.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

endmodule

[hw/rtl/htfd_front.sv]
// Front part of the frame decoder: tracks the byte position, runs the CRC-8
// and collects the raw words. Depends on htfd_pkg.
module htfd_front import htfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  input  logic       bus_error_i,
  output push_t      push_o
);

  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_raw_q, temp_raw_d;
  logic [15:0] humid_raw_q, humid_raw_d;
  logic        temp_ok_q, temp_ok_d;
  logic [2:0]  pos;
  logic [7:0]  crc_run;
  logic [1:0]  status;

  // Effective position: a frame start or an out-of-range count restarts the frame.
  always_comb begin
    if (frame_start_i || byte_pos_q > POS_H_CRC) begin
      pos = POS_T_MSB;
    end else begin
      pos = byte_pos_q;
    end
  end

  // CRC update; the first byte of each word starts from the preset.
  assign crc_run = crc8_byte((pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_q,
                             rx_byte_i);

  // Status of a complete frame, in priority order.
  always_comb begin
    if (bus_error_i) begin
      status = ST_BUS_ERR;
    end else if (!temp_ok_q) begin
      status = ST_TEMP_CRC;
    end else if (crc_q != rx_byte_i) begin
      status = ST_HUM_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // Next state for each byte of the frame.
  always_comb begin
    byte_pos_d  = byte_pos_q;
    crc_d       = crc_q;
    temp_raw_d  = temp_raw_q;
    humid_raw_d = humid_raw_q;
    temp_ok_d   = temp_ok_q;
    if (accept_i) begin
      case (pos)
        POS_T_MSB: begin
          crc_d      = crc_run;
          temp_raw_d = {rx_byte_i, temp_raw_q[7:0]};
          byte_pos_d = POS_T_LSB;
        end
        POS_T_LSB: begin
          crc_d      = crc_run;
          temp_raw_d = {temp_raw_q[15:8], rx_byte_i};
          byte_pos_d = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_ok_d  = (crc_q == rx_byte_i);
          crc_d      = CRC_INIT;
          byte_pos_d = POS_H_MSB;
        end
        POS_H_MSB: begin
          crc_d       = crc_run;
          humid_raw_d = {rx_byte_i, humid_raw_q[7:0]};
          byte_pos_d  = POS_H_LSB;
        end
        POS_H_LSB: begin
          crc_d       = crc_run;
          humid_raw_d = {humid_raw_q[15:8], rx_byte_i};
          byte_pos_d  = POS_H_CRC;
        end
        default: begin
          crc_d      = CRC_INIT;
          byte_pos_d = POS_T_MSB;
        end
      endcase
    end
  end

  // The sixth byte hands a finished frame to the queue.
  always_comb begin
    push_o.valid         = accept_i && (pos == POS_H_CRC);
    push_o.job.status    = status;
    push_o.job.temp_raw  = temp_raw_q;
    push_o.job.humid_raw = humid_raw_q;
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= POS_T_MSB;
      crc_q       <= CRC_INIT;
      temp_raw_q  <= '0;
      humid_raw_q <= '0;
      temp_ok_q   <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      crc_q       <= crc_d;
      temp_raw_q  <= temp_raw_d;
      humid_raw_q <= humid_raw_d;
      temp_ok_q   <= temp_ok_d;
    end
  end

endmodule

[hw/rtl/htfd_queue.sv]
// Short job queue that decouples frame decoding from conversion.
// Depends on htfd_pkg.
module htfd_queue import htfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output job_t   head_o,
  output qstat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  job_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/htfd_back.sv]
// Back part of the frame decoder: two-stage conversion pipeline from raw words
// to scaled readings, ending in the output register. Depends on htfd_pkg.
module htfd_back import htfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               head_i,
  input  qstat_t             qstat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [14:0] temp_centi_c_o,
  output logic signed [15:0] temp_centi_f_o,
  output logic [13:0]        humid_centi_pct_o
);

  // Product stage.
  logic        a_valid_q;
  logic [1:0]  a_status_q;
  logic [30:0] a_tc_q, a_tf_q, a_hp_q;
  // Output stage.
  logic        o_valid_q;
  logic [1:0]  o_status_q;
  logic [14:0] o_tc_q;
  logic [15:0] o_tf_q;
  logic [13:0] o_hp_q;
  logic        adv_o, adv_a;
  logic [14:0] q_tc, q_tf, q_hp;
  logic [15:0] tc_val, tf_val;

  // A stage moves when it is empty or its successor moves.
  assign adv_o = !o_valid_q || !out_stall_i;
  assign adv_a = !a_valid_q || adv_o;
  assign pop_o = adv_a && !qstat_i.empty;

  // Quotients by full scale, then the offsets.
  assign q_tc   = div_full_scale(a_tc_q);
  assign q_tf   = div_full_scale(a_tf_q);
  assign q_hp   = div_full_scale(a_hp_q);
  assign tc_val = {1'b0, q_tc} - TEMP_C_OFS;
  assign tf_val = {1'b0, q_tf} - TEMP_F_OFS;

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= !qstat_i.empty;
      end
      if (adv_o) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  // Scale products of the raw words.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_status_q <= head_i.status;
      a_tc_q     <= 31'(head_i.temp_raw * TEMP_C_SCALE);
      a_tf_q     <= 31'(head_i.temp_raw * TEMP_F_SCALE);
      a_hp_q     <= 31'(head_i.humid_raw * HUM_SCALE);
    end
  end

  // Output register; readings are zero unless the frame is good.
  always_ff @(posedge clk_i) begin
    if (adv_o && a_valid_q) begin
      o_status_q <= a_status_q;
      if (a_status_q == ST_OK) begin
        o_tc_q <= tc_val[14:0];
        o_tf_q <= tf_val;
        o_hp_q <= q_hp[13:0];
      end else begin
        o_tc_q <= '0;
        o_tf_q <= '0;
        o_hp_q <= '0;
      end
    end
  end

  assign out_valid_o       = o_valid_q;
  assign status_o          = o_status_q;
  assign temp_centi_c_o    = o_tc_q;
  assign temp_centi_f_o    = o_tf_q;
  assign humid_centi_pct_o = o_hp_q;

endmodule
